[hw/rtl/kdeq_pkg.sv]
// kdeq_pkg: shared types, constants and label function for the key debounce event queue
`timescale 1ns / 1ps
`default_nettype none

package kdeq_pkg;

  localparam int unsigned PinW     = 13;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned FillW    = 4;
  localparam int unsigned CntW     = 4;
  localparam int unsigned IntvW    = 16;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CodeW-1:0] LabelA     = 8'h61;
  localparam logic [CodeW-1:0] LabelN     = 8'h6e;
  localparam logic [CodeW-1:0] LabelSplit = 8'd12;

  typedef enum logic [1:0] {
    ActNone    = 2'd0,
    ActPress   = 2'd1,
    ActRelease = 2'd2
  } action_e;

  typedef enum logic {
    CfgThreshold = 1'b0,
    CfgInterval  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PinW-1:0]  pin_levels;
    logic [TimeW-1:0] now_ms;
    logic             host_busy;
    logic             press_accepted;
  } in_data_t;

  typedef struct packed {
    action_e          action;
    logic [CodeW-1:0] key_code;
    logic [FillW-1:0] queue_fill;
  } out_data_t;

  typedef struct packed {
    logic [CntW-1:0]  threshold;
    logic [IntvW-1:0] interval;
  } cfg_t;

  function automatic logic [CodeW-1:0] channel_label(input logic [CodeW-1:0] ch);
    logic [CodeW-1:0] lbl;
    if (ch < LabelSplit) begin
      lbl = LabelA + ch;
    end else begin
      lbl = LabelN + (ch - LabelSplit);
    end
    return lbl;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/kdeq_lane.sv]
// kdeq_lane: debounce counter and emit-interval check for one key channel
`timescale 1ns / 1ps
`default_nettype none

module kdeq_lane (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           load_i,
  input  wire logic                           active_i,
  input  wire logic [kdeq_pkg::TimeW-1:0]     now_i,
  input  wire kdeq_pkg::cfg_t                 cfg_i,
  output logic                                emit_o
);

  logic                          stable_q, stable_d;
  logic                          sample_q, sample_d;
  logic [kdeq_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [kdeq_pkg::TimeW-1:0]    last_q, last_d;
  logic [kdeq_pkg::TimeW-1:0]    elapsed;

  assign elapsed = now_i - last_q;

  always_comb begin
    stable_d = stable_q;
    sample_d = sample_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    emit_o   = 1'b0;
    if (en_i) begin
      if (load_i) begin
        stable_d = active_i;
        sample_d = active_i;
      end else if (active_i != sample_q) begin
        sample_d = active_i;
        cnt_d    = '0;
      end else if (cnt_q < cfg_i.threshold) begin
        cnt_d = cnt_q + 1'b1;
      end else if (stable_q != sample_q) begin
        stable_d = sample_q;
        if (elapsed >= {{(kdeq_pkg::TimeW-kdeq_pkg::IntvW){1'b0}}, cfg_i.interval}) begin
          last_d = now_i;
          emit_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      sample_q <= 1'b0;
      cnt_q    <= '0;
      last_q   <= '0;
    end else begin
      stable_q <= stable_d;
      sample_q <= sample_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/kdeq_merge.sv]
// kdeq_merge: walks lane emit flags in channel order and pushes labels into the event queue
`timescale 1ns / 1ps
`default_nettype none

module kdeq_merge #(
  parameter int unsigned NUM_CHANNELS = 13,
  parameter int unsigned QUEUE_DEPTH  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire logic [NUM_CHANNELS-1:0]         emit_i,
  input  wire logic                            pop_i,
  output logic [kdeq_pkg::CodeW-1:0]           head_o,
  output logic                                 not_empty_o,
  output logic [kdeq_pkg::FillW-1:0]           fill_o,
  output logic                                 busy_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned ChW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [ChW-1:0]  ChLast  = ChW'(NUM_CHANNELS - 1);

  logic [kdeq_pkg::CodeW-1:0] mem [QUEUE_DEPTH];
  logic [kdeq_pkg::CodeW-1:0] head_q;
  logic [PtrW-1:0]            rp_q, rp_d, wp_q, wp_d, rp_next, wp_next;
  logic [NUM_CHANNELS-1:0]    emit_q, emit_d;
  logic [ChW-1:0]             idx_q, idx_d;
  logic                       walk_q, walk_d;
  logic                       full;
  logic                       push;
  logic [PtrW:0]              fill_full;

  assign rp_next     = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
  assign wp_next     = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
  assign full        = (wp_next == rp_q);
  assign not_empty_o = (rp_q != wp_q);
  assign push        = walk_q && emit_q[idx_q] && !full;
  assign head_o      = head_q;
  assign busy_o      = walk_q;

  assign fill_full = (wp_q >= rp_q) ? ({1'b0, wp_q} - {1'b0, rp_q})
                                    : ({1'b0, wp_q} + (PtrW+1)'(QUEUE_DEPTH) - {1'b0, rp_q});
  assign fill_o    = kdeq_pkg::FillW'(fill_full);

  always_comb begin
    rp_d   = rp_q;
    wp_d   = wp_q;
    emit_d = emit_q;
    idx_d  = idx_q;
    walk_d = walk_q;
    if (pop_i) begin
      rp_d = rp_next;
    end
    if (load_i) begin
      emit_d = emit_i;
      idx_d  = '0;
      walk_d = 1'b1;
    end else if (walk_q) begin
      if (push) begin
        wp_d = wp_next;
      end
      if (idx_q == ChLast) begin
        walk_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      wp_q   <= '0;
      emit_q <= '0;
      idx_q  <= '0;
      walk_q <= 1'b0;
    end else begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      emit_q <= emit_d;
      idx_q  <= idx_d;
      walk_q <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wp_q] <= kdeq_pkg::channel_label(kdeq_pkg::CodeW'(idx_q));
    end
    head_q <= mem[rp_q];
  end

endmodule

`default_nettype wire

[hw/rtl/key_debounce_event_queue.sv]
// key_debounce_event_queue: top level with output stage, debounce lanes and event queue
// a new tick is accepted only once the previous result is in the output register;
// the merge walker visits one channel per cycle and pushes at most one label per cycle
//   into the event queue
// reset: clears pointers, lane state, held key and flags; config returns to 4 and 20 ms;
//   queue storage is not cleared
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_event_queue #(
  parameter int unsigned NUM_CHANNELS = 13,
  parameter int unsigned QUEUE_DEPTH  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire kdeq_pkg::in_data_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output kdeq_pkg::out_data_t                    out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire kdeq_pkg::cfg_idx_e                cfg_idx_i,
  input  wire logic [kdeq_pkg::CfgDataW-1:0]     cfg_data_i
);

  typedef enum logic {
    S_IDLE,
    S_FLUSH
  } state_e;

  state_e                       state_q;
  kdeq_pkg::cfg_t               cfg_q;
  logic                         init_q;
  logic                         key_held_q;
  logic [kdeq_pkg::CodeW-1:0]   held_code_q;
  kdeq_pkg::action_e            res_action_q;
  logic [kdeq_pkg::CodeW-1:0]   res_code_q;
  logic                         out_valid_q;
  kdeq_pkg::out_data_t          out_data_q;

  logic                         accept;
  logic                         pop;
  logic                         res_fire;
  logic [NUM_CHANNELS-1:0]      active;
  logic [NUM_CHANNELS-1:0]      emit;
  logic [kdeq_pkg::CodeW-1:0]   head;
  logic                         not_empty;
  logic [kdeq_pkg::FillW-1:0]   fill;
  logic                         merge_busy;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign pop         = accept && !in_data_i.host_busy && !key_held_q && not_empty;
  assign res_fire    = (state_q == S_FLUSH) && !merge_busy && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= kdeq_pkg::CntW'(4);
      cfg_q.interval  <= kdeq_pkg::IntvW'(20);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kdeq_pkg::CfgThreshold: cfg_q.threshold <= cfg_data_i[kdeq_pkg::CntW-1:0];
        kdeq_pkg::CfgInterval:  cfg_q.interval  <= cfg_data_i[kdeq_pkg::IntvW-1:0];
        default:                cfg_q           <= cfg_q;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
    if (i < kdeq_pkg::PinW) begin : g_pin
      assign active[i] = ~in_data_i.pin_levels[i];
    end else begin : g_nopin
      assign active[i] = 1'b1;
    end

    kdeq_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .load_i   (!init_q),
      .active_i (active[i]),
      .now_i    (in_data_i.now_ms),
      .cfg_i    (cfg_q),
      .emit_o   (emit[i])
    );
  end

  kdeq_merge #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .emit_i      (emit),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .fill_o      (fill),
    .busy_o      (merge_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      init_q       <= 1'b0;
      key_held_q   <= 1'b0;
      held_code_q  <= '0;
      res_action_q <= kdeq_pkg::ActNone;
      res_code_q   <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            init_q <= 1'b1;
            priority if (!in_data_i.host_busy && key_held_q) begin
              key_held_q   <= 1'b0;
              res_action_q <= kdeq_pkg::ActRelease;
              res_code_q   <= held_code_q;
            end else if (pop) begin
              held_code_q  <= head;
              key_held_q   <= in_data_i.press_accepted;
              res_action_q <= kdeq_pkg::ActPress;
              res_code_q   <= head;
            end else begin
              res_action_q <= kdeq_pkg::ActNone;
              res_code_q   <= '0;
            end
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (res_fire) begin
            out_data_q.action     <= res_action_q;
            out_data_q.key_code   <= res_code_q;
            out_data_q.queue_fill <= fill;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_while_merging: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && merge_busy)
  ) else $error("tick accepted while merge walk still running");

  a_result_from_flush: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_o) |-> $past(state_q == S_FLUSH)
  ) else $error("result beat appeared outside flush");

  a_pop_only_when_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni) pop |-> (!key_held_q && not_empty)
  ) else $error("queue popped while a key is held or queue empty");
`endif

endmodule

`default_nettype wire
